// ----- rtl/fcd_pkg.sv -----
// Package for the force click detector: widths, reset values, register
// indexes and the payload and status types shared by every RTL file.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

   localparam int SAMPLE_W = 12;
   localparam int TIME_W = 16;
   localparam int COUNT_W = 4;
   localparam int DELTA_W = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int SUM_W = SAMPLE_W + 2;

   localparam int CALIBRATION_SAMPLES_DEFAULT = 10;

   localparam logic [DELTA_W-1:0] PRESS_MARGIN_RESET = DELTA_W'(50);
   localparam logic HAPTIC_GATE_ENABLE_RESET = 1'b0;
   localparam logic [TIME_W-1:0] GATE_HOLD_MS_RESET = TIME_W'(200);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(2047);

   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_MARGIN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HAPTIC_GATE_ENABLE = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_HOLD_MS = CSR_INDEX_W'(2);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic sample_ok;
      logic haptic_playing;
      logic [TIME_W-1:0] elapsed_ms;
   } req_payload_type;

   typedef struct packed {
      logic key_event;
      logic key_value;
      logic is_pressed;
      logic is_calibrated;
      logic suppressed;
   } rsp_payload_type;

   typedef struct packed {
      logic calibrated;
      logic calibrated_next;
      logic signed [SAMPLE_W-1:0] baseline;
   } calib_status_type;

   typedef struct packed {
      logic [DELTA_W-1:0] press_margin;
      logic haptic_gate_enable;
      logic [TIME_W-1:0] gate_hold_ms;
   } csr_type;

endpackage

`default_nettype wire

// ----- rtl/fcd_if.sv -----
// Valid/ready channel interfaces for the poll requests and key responses.
// Depends on fcd_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface fcd_req_if;
   logic valid;
   logic ready;
   fcd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fcd_rsp_if;
   logic valid;
   logic ready;
   fcd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/fcd_calib.sv -----
// Baseline calibration: running minimum, good sample count, baseline capture.
// Depends on fcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcd_calib #(
   parameter int CALIBRATION_SAMPLES = fcd_pkg::CALIBRATION_SAMPLES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic step_en,
   input wire logic signed [fcd_pkg::SAMPLE_W-1:0] sample,
   input wire logic sample_ok,
   output fcd_pkg::calib_status_type status
);

   logic signed [fcd_pkg::SAMPLE_W-1:0] run_min_ff, run_min_in;
   logic signed [fcd_pkg::SAMPLE_W-1:0] baseline_ff, baseline_in;
   logic [fcd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic calibrated_ff, calibrated_in;
   logic [fcd_pkg::COUNT_W:0] count_inc;
   logic signed [fcd_pkg::SAMPLE_W-1:0] new_min;

   always_comb begin
      run_min_in = run_min_ff;
      baseline_in = baseline_ff;
      count_in = count_ff;
      calibrated_in = calibrated_ff;
      count_inc = {1'b0, count_ff} + (fcd_pkg::COUNT_W+1)'(1);
      new_min = (sample < run_min_ff) ? sample : run_min_ff;
      if (!calibrated_ff) begin
         if (!sample_ok) begin
            run_min_in = fcd_pkg::SAMPLE_MAX;
            count_in = '0;
         end else if (count_inc >= (fcd_pkg::COUNT_W+1)'(CALIBRATION_SAMPLES)) begin
            baseline_in = new_min;
            calibrated_in = 1'b1;
            run_min_in = fcd_pkg::SAMPLE_MAX;
            count_in = '0;
         end else begin
            run_min_in = new_min;
            count_in = count_inc[fcd_pkg::COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= fcd_pkg::SAMPLE_MAX;
         baseline_ff <= '0;
         count_ff <= '0;
         calibrated_ff <= 1'b0;
      end else if (step_en) begin
         run_min_ff <= run_min_in;
         baseline_ff <= baseline_in;
         count_ff <= count_in;
         calibrated_ff <= calibrated_in;
      end
   end

   assign status.calibrated = calibrated_ff;
   assign status.calibrated_next = calibrated_in;
   assign status.baseline = baseline_ff;

endmodule

`default_nettype wire

// ----- rtl/fcd_detect.sv -----
// Haptic gate countdown and press detection against the captured baseline.
// Depends on fcd_pkg and the status from fcd_calib.
`timescale 1ns / 1ps
`default_nettype none

module fcd_detect (
   input wire logic clock,
   input wire logic reset,
   input wire logic step_en,
   input wire fcd_pkg::req_payload_type item,
   input wire fcd_pkg::calib_status_type status,
   input wire fcd_pkg::csr_type csr,
   output fcd_pkg::rsp_payload_type result
);

   logic [fcd_pkg::TIME_W-1:0] gate_ff, gate_in;
   logic pressed_ff, pressed_in;
   logic sup;
   logic now_pressed;
   logic signed [fcd_pkg::SUM_W-1:0] limit;
   logic signed [fcd_pkg::SUM_W-1:0] sample_ext;
   logic ev;

   always_comb begin
      limit = fcd_pkg::SUM_W'(status.baseline)
            + $signed({2'b00, csr.press_margin});
      sample_ext = fcd_pkg::SUM_W'(item.sample);
      now_pressed = sample_ext > limit;
      gate_in = gate_ff;
      pressed_in = pressed_ff;
      sup = 1'b0;
      ev = 1'b0;
      if (status.calibrated) begin
         if (csr.haptic_gate_enable) begin
            if (item.haptic_playing) begin
               gate_in = csr.gate_hold_ms;
            end else if (gate_ff > item.elapsed_ms) begin
               gate_in = gate_ff - item.elapsed_ms;
            end else begin
               gate_in = '0;
            end
            sup = (gate_in != '0);
         end
         if (!sup && item.sample_ok && (now_pressed != pressed_ff)) begin
            pressed_in = now_pressed;
            ev = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= '0;
         pressed_ff <= 1'b0;
      end else if (step_en) begin
         gate_ff <= gate_in;
         pressed_ff <= pressed_in;
      end
   end

   assign result.key_event = ev;
   assign result.key_value = ev & pressed_in;
   assign result.is_pressed = status.calibrated_next & pressed_in;
   assign result.is_calibrated = status.calibrated_next;
   assign result.suppressed = sup;

endmodule

`default_nettype wire

// ----- rtl/force_click_detector_unit.sv -----
// Force click detector top level: request register, calibration and
// detection logic, response register and configuration registers.
// Depends on fcd_pkg, fcd_if, fcd_calib and fcd_detect.
//
// Usage:
//   req_chan carries one poll per transaction (sample, sample_ok,
//   haptic_playing, elapsed_ms). rsp_chan returns exactly one response
//   per poll, in order: key_event, key_value, is_pressed, is_calibrated,
//   suppressed.
//   The poll is held in a request register, processed by combinational logic
//   and stored in a response register, from which it is offered on rsp_chan.
//   Throughput is one poll per cycle while the receiver does not stall.
//   When the receiver stalls, the response register holds, the request
//   register fills, and req_chan.ready drops until rsp_chan.ready returns.
//   Synchronous reset clears both pipeline stages, restarts calibration
//   (running minimum 2047, baseline 0), clears the pressed state and gate
//   countdown, and loads press margin 50, gate enable 0 and gate hold
//   time 200 ms. Configuration writes through csr_* take effect at the
//   next clock; write only while no poll is in flight.
`timescale 1ns / 1ps
`default_nettype none

module force_click_detector_unit #(
   parameter int CALIBRATION_SAMPLES = fcd_pkg::CALIBRATION_SAMPLES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   fcd_req_if.sink req_chan,
   fcd_rsp_if.source rsp_chan,
   input wire logic csr_wr_en,
   input wire logic [fcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [fcd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   fcd_pkg::req_payload_type req_data_ff;
   logic req_valid_ff;
   fcd_pkg::rsp_payload_type rsp_data_ff;
   logic rsp_valid_ff;
   fcd_pkg::csr_type csr_ff;
   fcd_pkg::calib_status_type status;
   fcd_pkg::rsp_payload_type result;
   logic advance;
   logic step_en;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign step_en = req_valid_ff && advance;
   assign req_chan.ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         req_data_ff <= req_chan.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.press_margin <= fcd_pkg::PRESS_MARGIN_RESET;
         csr_ff.haptic_gate_enable <= fcd_pkg::HAPTIC_GATE_ENABLE_RESET;
         csr_ff.gate_hold_ms <= fcd_pkg::GATE_HOLD_MS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            fcd_pkg::CSR_PRESS_MARGIN: begin
               csr_ff.press_margin <= csr_wdata[fcd_pkg::DELTA_W-1:0];
            end
            fcd_pkg::CSR_HAPTIC_GATE_ENABLE: begin
               csr_ff.haptic_gate_enable <= csr_wdata[0];
            end
            fcd_pkg::CSR_GATE_HOLD_MS: begin
               csr_ff.gate_hold_ms <= csr_wdata[fcd_pkg::TIME_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   fcd_calib #(
      .CALIBRATION_SAMPLES(CALIBRATION_SAMPLES)
   ) u_calib (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .sample(req_data_ff.sample),
      .sample_ok(req_data_ff.sample_ok),
      .status(status)
   );

   fcd_detect u_detect (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .item(req_data_ff),
      .status(status),
      .csr(csr_ff),
      .result(result)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for force_click_detector_unit: random poll traffic with
// bursts, receiver stalls and register phases, checked against a behavioral model.
// Depends on fcd_pkg, fcd_if and the force_click_detector_unit RTL.
`timescale 1ns / 1ps

module tb_top;
   import fcd_pkg::*;

   localparam int CAL_SAMPLES = CALIBRATION_SAMPLES_DEFAULT;
   localparam int SAMPLE_HI = int'(SAMPLE_MAX);
   localparam int SAMPLE_LO = -SAMPLE_HI - 1;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLDOFF_CYCLES = 100;
   localparam int PHASE_POLLS = 50;
   localparam int NUM_PHASES = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = CSR_INDEX_W'(3);

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fcd_req_if poll_if();
   fcd_rsp_if key_if();

   force_click_detector_unit #(
      .CALIBRATION_SAMPLES(CAL_SAMPLES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(poll_if),
      .rsp_chan(key_if),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // detector model state and register copies
   logic [DELTA_W-1:0] cfg_delta;
   logic cfg_gate_en;
   logic [TIME_W-1:0] cfg_gate_ms;
   logic signed [SAMPLE_W-1:0] baseline;
   logic signed [SAMPLE_W-1:0] run_min;
   logic [COUNT_W-1:0] good_count;
   logic model_calibrated;
   logic pressed;
   logic [TIME_W-1:0] gate_left;

   req_payload_type poll_queue[$];
   rsp_payload_type key_expected[$];
   int mismatch_count = 0;

   int burst_left;
   int gap_left;
   int hold_left;
   int pattern_age;
   int rsp_count;
   logic [7:0] ready_pattern;

   function automatic rsp_payload_type predict_key(input req_payload_type poll);
      rsp_payload_type key;
      int sample_i;
      logic now_pressed;
      key = '0;
      sample_i = $signed(poll.sample);
      if (!model_calibrated) begin
         if (!poll.sample_ok) begin
            run_min = SAMPLE_MAX;
            good_count = '0;
         end else begin
            if ($signed(poll.sample) < run_min)
               run_min = poll.sample;
            good_count = good_count + 1'b1;
            if (good_count >= CAL_SAMPLES) begin
               baseline = run_min;
               model_calibrated = 1'b1;
               run_min = SAMPLE_MAX;
               good_count = '0;
            end
         end
      end else begin
         if (cfg_gate_en) begin
            if (poll.haptic_playing)
               gate_left = cfg_gate_ms;
            else if (gate_left > poll.elapsed_ms)
               gate_left = gate_left - poll.elapsed_ms;
            else
               gate_left = '0;
            key.suppressed = (gate_left != '0);
         end
         if (!key.suppressed && poll.sample_ok) begin
            now_pressed = sample_i > (int'(baseline) + int'(cfg_delta));
            if (now_pressed != pressed) begin
               pressed = now_pressed;
               key.key_event = 1'b1;
               key.key_value = now_pressed;
            end
         end
      end
      key.is_pressed = model_calibrated && pressed;
      key.is_calibrated = model_calibrated;
      return key;
   endfunction

   function automatic req_payload_type random_poll();
      req_payload_type poll;
      int level;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         level = int'(baseline) + int'(cfg_delta) + int'($urandom_range(0, 6)) - 3;
         if (level > SAMPLE_HI)
            level = SAMPLE_HI;
         if (level < SAMPLE_LO)
            level = SAMPLE_LO;
      end else if (pick < 8) begin
         level = int'($urandom_range(0, 4095)) + SAMPLE_LO;
      end else begin
         case ($urandom_range(0, 3))
            0: level = SAMPLE_LO;
            1: level = SAMPLE_HI;
            2: level = 0;
            default: level = -1;
         endcase
      end
      poll.sample = level[SAMPLE_W-1:0];
      poll.sample_ok = ($urandom_range(0, 9) != 0);
      poll.haptic_playing = ($urandom_range(0, 6) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5)
         poll.elapsed_ms = TIME_W'($urandom_range(0, 20));
      else if (pick < 8)
         poll.elapsed_ms = TIME_W'($urandom_range(0, int'(cfg_gate_ms)));
      else
         poll.elapsed_ms = TIME_W'($urandom_range(0, 65535));
      return poll;
   endfunction

   task automatic add_poll(input int level, input bit ok, input bit playing, input int elapsed);
      req_payload_type poll;
      poll.sample = level[SAMPLE_W-1:0];
      poll.sample_ok = ok;
      poll.haptic_playing = playing;
      poll.elapsed_ms = elapsed[TIME_W-1:0];
      poll_queue.push_back(poll);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_PRESS_MARGIN: cfg_delta = data[DELTA_W-1:0];
         CSR_HAPTIC_GATE_ENABLE: cfg_gate_en = data[0];
         CSR_GATE_HOLD_MS: cfg_gate_ms = data[TIME_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (poll_queue.size() != 0 || poll_if.valid || key_expected.size() != 0);
   endtask

   task automatic check_bit(input string field, input logic want, input logic got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t %s: expected %0b, actual %0b", $time, field, want, got);
      end
   endtask

   // driver: bursts of transactions with random gaps
   always @(posedge clock) begin
      if (reset) begin
         poll_if.valid <= 1'b0;
         poll_if.payload <= '0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (poll_if.valid && poll_if.ready)
            key_expected.push_back(predict_key(poll_if.payload));
         if (!poll_if.valid || poll_if.ready) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
            if (gap_left > 0) begin
               gap_left--;
               poll_if.valid <= 1'b0;
            end else if (poll_queue.size() > 0) begin
               poll_if.payload <= poll_queue.pop_front();
               poll_if.valid <= 1'b1;
               burst_left--;
            end else begin
               poll_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare responses and stall on a rotating pattern
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         key_if.ready <= 1'b0;
         hold_left = 0;
         pattern_age = 0;
         rsp_count = 0;
         ready_pattern = 8'hFF;
      end else begin
         if (key_if.valid && key_if.ready) begin
            if (key_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected response: expected none, actual %b", $time,
                        key_if.payload);
            end else begin
               want = key_expected.pop_front();
               check_bit("key_event", want.key_event, key_if.payload.key_event);
               check_bit("key_value", want.key_value, key_if.payload.key_value);
               check_bit("is_pressed", want.is_pressed, key_if.payload.is_pressed);
               check_bit("is_calibrated", want.is_calibrated, key_if.payload.is_calibrated);
               check_bit("suppressed", want.suppressed, key_if.payload.suppressed);
            end
            rsp_count++;
            if (rsp_count == 120 || rsp_count == 300)
               hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0)
            hold_left--;
         if (pattern_age == 0) begin
            pattern_age = 32;
            ready_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
         end
         pattern_age--;
         ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
         key_if.ready <= (hold_left == 0) && ready_pattern[0];
      end
   end

   initial begin
      #2_000_000;
      $display("[force_click_detector_unit] ERROR");
      $finish;
   end

   initial begin
      int delta_set;
      int ms_set;
      bit en_set;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      poll_if.valid = 1'b0;
      poll_if.payload = '0;
      key_if.ready = 1'b0;
      cfg_delta = PRESS_MARGIN_RESET;
      cfg_gate_en = HAPTIC_GATE_ENABLE_RESET;
      cfg_gate_ms = GATE_HOLD_MS_RESET;
      baseline = '0;
      run_min = SAMPLE_MAX;
      good_count = '0;
      model_calibrated = 1'b0;
      pressed = 1'b0;
      gate_left = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // aborted calibration: the failed read must discard the low minimum
      add_poll(SAMPLE_LO, 1, 1, 0);
      add_poll(SAMPLE_HI, 1, 0, 65535);
      add_poll(100, 1, 1, 5);
      add_poll(5, 1, 0, 7);
      add_poll(SAMPLE_LO, 0, 0, 3);
      // full calibration, minimum -120, capturing item well above threshold
      add_poll(37, 1, 0, 1);
      add_poll(-120, 1, 1, 2);
      add_poll(512, 1, 0, 3);
      add_poll(0, 1, 0, 4);
      add_poll(300, 1, 1, 5);
      add_poll(-1, 1, 0, 6);
      add_poll(1000, 1, 0, 7);
      add_poll(-64, 1, 0, 8);
      add_poll(250, 1, 0, 9);
      add_poll(SAMPLE_HI, 1, 0, 10);
      // detection at reset settings, gate disabled
      add_poll(-70, 1, 0, 10);
      add_poll(-69, 1, 0, 10);
      add_poll(-69, 1, 0, 0);
      add_poll(SAMPLE_LO, 0, 0, 10);
      add_poll(SAMPLE_LO, 1, 0, 65535);
      add_poll(SAMPLE_HI, 1, 1, 10);
      add_poll(-70, 1, 1, 10);
      wait_drained();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin delta_set = 0; en_set = 1'b1; ms_set = 200; end
            1: begin delta_set = 4095; en_set = 1'b1; ms_set = 65535; end
            2: begin delta_set = 0; en_set = 1'b1; ms_set = 0; end
            3: begin delta_set = 0; en_set = 1'b0; ms_set = 65535; end
            4: begin delta_set = 200; en_set = 1'b1; ms_set = 1; end
            default: begin
               delta_set = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300)
                                                       : $urandom_range(0, 4095);
               en_set = $urandom_range(0, 1);
               ms_set = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                    : $urandom_range(0, 400);
            end
         endcase
         write_reg(CSR_PRESS_MARGIN, CSR_DATA_W'(delta_set));
         write_reg(CSR_HAPTIC_GATE_ENABLE, CSR_DATA_W'(en_set));
         write_reg(CSR_GATE_HOLD_MS, CSR_DATA_W'(ms_set));
         if (phase == 0)
            write_reg(CSR_INDEX_UNUSED, '1);
         repeat (PHASE_POLLS) poll_queue.push_back(random_poll());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[force_click_detector_unit] OK");
      else
         $display("[force_click_detector_unit] ERROR");
      $finish;
   end

endmodule
